### rtl/core/idiv_pkg.sv
// Package for the 64-bit integer divider: widths, stage payload types.
// Used by the channel interfaces and every module of the divider.
package idiv_pkg;

	localparam int FIELD_W = 64;
	localparam int DATA_W  = 64;

	typedef struct packed {
		logic              sgn_q;
		logic              sgn_r;
		logic              dz;
		logic [DATA_W-1:0] nq;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] den;
	} idiv_work_t;

	typedef struct packed {
		logic [FIELD_W-1:0] quotient;
		logic [FIELD_W-1:0] remainder;
		logic               div_by_zero;
	} idiv_result_t;

endpackage

### rtl/core/idiv_req_if.sv
// Request channel of the divider: valid, ready and the operand item.
// Depends on idiv_pkg for the field width.
interface idiv_req_if import idiv_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [FIELD_W-1:0] dividend;
	logic [FIELD_W-1:0] divisor;

	modport source (output valid, output cmd, output dividend, output divisor, input ready);
	modport sink (input valid, input cmd, input dividend, input divisor, output ready);
endinterface

### rtl/core/idiv_rsp_if.sv
// Response channel of the divider: valid, ready and the result item.
// Depends on idiv_pkg for the field width.
interface idiv_rsp_if import idiv_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] quotient;
	logic [FIELD_W-1:0] remainder;
	logic               div_by_zero;

	modport source (output valid, output quotient, output remainder, output div_by_zero,
		input ready);
	modport sink (input valid, input quotient, input remainder, input div_by_zero,
		output ready);
endinterface

### rtl/core/idiv_prep.sv
// Input stage of the divider: operand magnitudes, sign flags, zero divisor.
// Depends on idiv_pkg.
module idiv_prep import idiv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic               cmd,
	input  logic [FIELD_W-1:0] dividend,
	input  logic [FIELD_W-1:0] divisor,
	output logic               out_valid,
	output idiv_work_t         out_work
);

	logic              valid_s1;
	idiv_work_t        work_s1;
	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] b;
	logic              neg_a;
	logic              neg_b;
	logic [DATA_W-1:0] a_mag;
	logic [DATA_W-1:0] b_mag;
	idiv_work_t        work_d;

	always_comb begin
		a      = dividend[DATA_W-1:0];
		b      = divisor[DATA_W-1:0];
		neg_a  = cmd & a[DATA_W-1];
		neg_b  = cmd & b[DATA_W-1];
		a_mag  = neg_a ? (~a + DATA_W'(1)) : a;
		b_mag  = neg_b ? (~b + DATA_W'(1)) : b;
		work_d.sgn_q = neg_a ^ neg_b;
		work_d.sgn_r = neg_a;
		work_d.dz    = (b_mag == '0);
		work_d.nq    = a_mag;
		work_d.rem   = '0;
		work_d.den   = b_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

### rtl/core/idiv_step.sv
// One restoring shift-subtract stage of the divider, one quotient bit.
// Depends on idiv_pkg.
module idiv_step import idiv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  idiv_work_t in_work,
	output logic       out_valid,
	output idiv_work_t out_work
);

	logic              valid_s1;
	idiv_work_t        work_s1;
	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] diff;
	logic              ge;
	idiv_work_t        work_d;

	always_comb begin
		trial = {in_work.rem, in_work.nq[DATA_W-1]};
		diff  = {1'b0, trial} - {2'b00, in_work.den};
		ge    = ~diff[DATA_W+1];
		work_d     = in_work;
		work_d.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		work_d.nq  = {in_work.nq[DATA_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

### rtl/core/idiv_fix.sv
// Output stage of the divider: result signs, zero divisor remainder.
// Depends on idiv_pkg.
module idiv_fix import idiv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  idiv_work_t   in_work,
	output logic         out_valid,
	output idiv_result_t out_result
);

	logic              valid_s1;
	idiv_result_t      result_s1;
	logic [DATA_W-1:0] q;
	logic [DATA_W-1:0] r;
	idiv_result_t      result_d;

	always_comb begin
		q = in_work.sgn_q ? (~in_work.nq + DATA_W'(1)) : in_work.nq;
		if (in_work.dz) begin
			r = '0;
		end else begin
			r = in_work.sgn_r ? (~in_work.rem + DATA_W'(1)) : in_work.rem;
		end
		result_d.quotient    = FIELD_W'(q);
		result_d.remainder   = FIELD_W'(r);
		result_d.div_by_zero = in_work.dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s1 <= result_d;
		end
	end

	assign out_valid  = valid_s1;
	assign out_result = result_s1;

endmodule

### rtl/core/idiv_skid.sv
// Two-entry output buffer of the divider; its registered ready moves the pipeline.
// Depends on idiv_pkg and idiv_rsp_if.
module idiv_skid import idiv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  idiv_result_t  in_result,
	output logic          en,
	idiv_rsp_if.source    rsp
);

	logic         main_valid_q;
	logic         spare_valid_q;
	idiv_result_t main_q;
	idiv_result_t spare_q;
	logic         push;
	logic         pop;

	assign en   = ~spare_valid_q;
	assign push = in_valid & ~spare_valid_q;
	assign pop  = main_valid_q & rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (pop) begin
			if (spare_valid_q) begin
				spare_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				spare_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (spare_valid_q) begin
				main_q <= spare_q;
			end else if (push) begin
				main_q <= in_result;
			end
		end else if (push) begin
			if (main_valid_q) begin
				spare_q <= in_result;
			end else begin
				main_q <= in_result;
			end
		end
	end

	assign rsp.valid       = main_valid_q;
	assign rsp.quotient    = main_q.quotient;
	assign rsp.remainder   = main_q.remainder;
	assign rsp.div_by_zero = main_q.div_by_zero;

endmodule

### rtl/core/integer_divider_64_unit.sv
// Top level of the pipelined 64-bit integer divider, quotient and remainder.
// Depends on idiv_pkg, idiv_req_if, idiv_rsp_if, idiv_prep, idiv_step, idiv_fix, idiv_skid.
//
//   channel  dir  item fields
//   req      in   cmd, dividend, divisor
//   rsp      out  quotient, remainder, div_by_zero
//
// One item enters per cycle while req.ready is high; there is one stage per quotient bit,
// and an item passes the input stage, DATA_W divide stages, the sign stage and the output
// buffer on its way to rsp.
// Reset clears only the valid bits. The output buffer holds two items; when its
// second entry fills, req.ready drops and the whole pipeline holds in place.
module integer_divider_64_unit import idiv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	idiv_req_if.sink   req,
	idiv_rsp_if.source rsp
);

	logic         en;
	logic         stg_valid [0:DATA_W];
	idiv_work_t   stg_work  [0:DATA_W];
	logic         fix_valid;
	idiv_result_t fix_result;

	assign req.ready = en;

	idiv_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.cmd       (req.cmd),
		.dividend  (req.dividend),
		.divisor   (req.divisor),
		.out_valid (stg_valid[0]),
		.out_work  (stg_work[0])
	);

	for (genvar i = 0; i < DATA_W; i++) begin : g_step
		idiv_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stg_valid[i]),
			.in_work   (stg_work[i]),
			.out_valid (stg_valid[i+1]),
			.out_work  (stg_work[i+1])
		);
	end

	idiv_fix u_fix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (stg_valid[DATA_W]),
		.in_work    (stg_work[DATA_W]),
		.out_valid  (fix_valid),
		.out_result (fix_result)
	);

	idiv_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fix_valid),
		.in_result (fix_result),
		.en        (en),
		.rsp       (rsp)
	);

endmodule

### verif/idiv_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the 64-bit integer divider: it predicts quotient, remainder and the
// division-by-zero flag of every accepted operand item and compares them with the results.
// Depends on idiv_pkg and on the idiv_req_if and idiv_rsp_if channel interfaces.
module idiv_result_checker import idiv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	idiv_req_if  req,
	idiv_rsp_if  rsp,
	output int   mismatch_count,
	output int   pending_count
);

	idiv_result_t expected_q[$];
	int mismatches = 0;
	int pending = 0;

	assign mismatch_count = mismatches;
	assign pending_count  = pending;

	function automatic idiv_result_t predict_division(input logic cmd,
		input logic [DATA_W-1:0] dividend, input logic [DATA_W-1:0] divisor);
		idiv_result_t res;
		logic neg_a, neg_b;
		logic [DATA_W-1:0] mag_a, mag_b, quo, rem;
		neg_a = cmd & dividend[DATA_W-1];
		neg_b = cmd & divisor[DATA_W-1];
		mag_a = neg_a ? -dividend : dividend;
		mag_b = neg_b ? -divisor : divisor;
		quo = '0;
		rem = '0;
		if (mag_b == '0) begin
			quo = '1;
		end else begin
			for (int i = DATA_W - 1; i >= 0; i--) begin
				rem = {rem[DATA_W-2:0], mag_a[i]};
				if (rem >= mag_b) begin
					rem = rem - mag_b;
					quo[i] = 1'b1;
				end
			end
		end
		if (neg_a != neg_b)
			quo = -quo;
		if (neg_a)
			rem = -rem;
		res.quotient    = quo;
		res.remainder   = rem;
		res.div_by_zero = (mag_b == '0);
		return res;
	endfunction

	always @(posedge clk) begin : watch_channels
		idiv_result_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_q.push_back(predict_division(req.cmd, req.dividend, req.divisor));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result item, expected none, got q=%h r=%h dz=%b",
						$time, rsp.quotient, rsp.remainder, rsp.div_by_zero);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.quotient !== want.quotient) begin
						$display("%0t: quotient mismatch, expected %h, got %h",
							$time, want.quotient, rsp.quotient);
						mismatches++;
					end
					if (rsp.remainder !== want.remainder) begin
						$display("%0t: remainder mismatch, expected %h, got %h",
							$time, want.remainder, rsp.remainder);
						mismatches++;
					end
					if (rsp.div_by_zero !== want.div_by_zero) begin
						$display("%0t: div_by_zero mismatch, expected %b, got %b",
							$time, want.div_by_zero, rsp.div_by_zero);
						mismatches++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for integer_divider_64_unit: clock, reset, operand stimulus and result stalls.
// Depends on idiv_pkg, the channel interfaces, the divider RTL and idiv_result_checker.
module tb_top;
	import idiv_pkg::*;

	localparam logic CMD_UNSIGNED = 1'b0;
	localparam logic CMD_SIGNED   = 1'b1;
	localparam int   IDLE_PCT     = 26;
	localparam int   RANDOM_ITEMS = 1650;
	localparam logic [DATA_W-1:0] ALL_ONES = '1;
	localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   gaps_on = 1'b1;
	int   mismatch_count;
	int   pending_count;

	idiv_req_if req_ch ();
	idiv_rsp_if rsp_ch ();

	integer_divider_64_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	idiv_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] rand_operand();
		logic [DATA_W-1:0] full;
		full = DATA_W'({$urandom, $urandom});
		case ($urandom_range(9))
			0, 1, 2, 3: return full;
			4, 5, 6: return full >> $urandom_range(DATA_W - 1);
			7: begin
				case ($urandom_range(5))
					0: return '0;
					1: return DATA_W'(1);
					2: return ALL_ONES;
					3: return MOST_NEG;
					4: return MOST_POS;
					default: return MOST_NEG + DATA_W'(1);
				endcase
			end
			8: return DATA_W'($urandom_range(16));
			default: return -(full >> $urandom_range(DATA_W - 1));
		endcase
	endfunction

	task automatic send_division(input logic cmd, input logic [DATA_W-1:0] dividend,
		input logic [DATA_W-1:0] divisor);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.cmd      <= cmd;
		req_ch.dividend <= dividend;
		req_ch.divisor  <= divisor;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin
		req_ch.valid    <= 1'b0;
		req_ch.cmd      <= CMD_UNSIGNED;
		req_ch.dividend <= '0;
		req_ch.divisor  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_division(CMD_UNSIGNED, DATA_W'(0), DATA_W'(1));
		send_division(CMD_UNSIGNED, ALL_ONES, DATA_W'(1));
		send_division(CMD_UNSIGNED, ALL_ONES, ALL_ONES);
		send_division(CMD_UNSIGNED, DATA_W'(12345), DATA_W'(7));
		send_division(CMD_UNSIGNED, DATA_W'(3), ALL_ONES);
		send_division(CMD_UNSIGNED, MOST_NEG, DATA_W'(2));
		send_division(CMD_UNSIGNED, DATA_W'(5), DATA_W'(0));
		send_division(CMD_UNSIGNED, DATA_W'(0), DATA_W'(0));
		send_division(CMD_UNSIGNED, ALL_ONES, DATA_W'(0));
		send_division(CMD_SIGNED, MOST_NEG, ALL_ONES);
		send_division(CMD_SIGNED, MOST_NEG, DATA_W'(1));
		send_division(CMD_SIGNED, -64'd7, DATA_W'(2));
		send_division(CMD_SIGNED, DATA_W'(7), -64'd2);
		send_division(CMD_SIGNED, -64'd7, -64'd2);
		send_division(CMD_SIGNED, -64'd5, DATA_W'(0));
		send_division(CMD_SIGNED, DATA_W'(5), DATA_W'(0));
		send_division(CMD_SIGNED, DATA_W'(0), DATA_W'(0));
		send_division(CMD_SIGNED, MOST_POS, MOST_NEG);
		send_division(CMD_SIGNED, MOST_NEG, MOST_NEG);
		send_division(CMD_SIGNED, ALL_ONES, MOST_NEG);
		send_division(CMD_SIGNED, MOST_POS, ALL_ONES);
		send_division(CMD_SIGNED, MOST_NEG, MOST_POS);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gaps_on = !(n >= 500 && n < 800);
			if (n == 1000)
				drain_results();
			send_division(1'($urandom_range(1)), rand_operand(), rand_operand());
		end
		gaps_on = 1'b1;

		drain_results();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("integer_divider_64_unit verification clean");
		else
			$display("integer_divider_64_unit verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("integer_divider_64_unit verification failed");
		$finish;
	end

endmodule
